// File: src/bmpt_pkg.sv
// ----------------------------------------------------------------------------
// bmpt_pkg: shared types and constants
// Field structs, operation and status codes, and control state for the
// factorial table block.
// ----------------------------------------------------------------------------
package bmpt_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int VAL_W       = 30;
    localparam logic [VAL_W-1:0] PRIME_MOD    = 30'd1000000007;
    localparam logic [31:0]      INV_EXPONENT = 32'd1000000005;

    localparam logic [1:0] OP_EXTEND  = 2'd0;
    localparam logic [1:0] OP_COMBINE = 2'd1;
    localparam logic [1:0] OP_PERMUTE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_BUILT = 2'd1;
    localparam logic [1:0] ST_R_GT_N   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] top_index;
        logic [11:0] choose_count;
    } bmpt_in_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [1:0]       status;
    } bmpt_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_MUL1,
        S_WAIT1,
        S_MUL2,
        S_WAIT2,
        S_RD3,
        S_MUL3,
        S_WAIT3,
        S_POW_SQ,
        S_POW_SQW,
        S_POW_ML,
        S_POW_MLW,
        S_WRITE,
        S_DONE
    } bmpt_state_t;

endpackage

// File: src/bmpt_mulmod.sv
// ----------------------------------------------------------------------------
// bmpt_mulmod: bit-serial modular multiplier
// Computes a*b mod PRIME_MOD by shift-and-add, one bit of b per cycle, with
// the running value held below the modulus by compare and subtract.
// ----------------------------------------------------------------------------
module bmpt_mulmod
    import bmpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [VAL_W-1:0] a,
    input  logic [VAL_W-1:0] b,
    output logic             done,
    output logic [VAL_W-1:0] product
);

    logic [VAL_W-1:0]         acc_reg, acc_next;
    logic [VAL_W-1:0]         a_reg;
    logic [VAL_W-1:0]         b_reg;
    logic [$clog2(VAL_W)-1:0] cnt_reg;
    logic                     run_reg;
    logic                     done_reg;

    logic [VAL_W:0] dbl, dbl_m, add, add_m;

    // Horner step: acc = 2*acc (+ a), each reduced once.
    always_comb
    begin
        dbl   = {acc_reg, 1'b0};
        dbl_m = (dbl >= {1'b0, PRIME_MOD}) ? dbl - {1'b0, PRIME_MOD} : dbl;
        add   = dbl_m + (b_reg[VAL_W-1] ? {1'b0, a_reg} : '0);
        add_m = (add >= {1'b0, PRIME_MOD}) ? add - {1'b0, PRIME_MOD} : add;
        acc_next = add_m[VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ($clog2(VAL_W))'(VAL_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            acc_reg <= '0;
            // Operand a may reach the modulus range edge; reduce it once.
            a_reg   <= (a >= PRIME_MOD) ? a - PRIME_MOD : a;
            b_reg   <= b;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[VAL_W-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// File: src/binomial_mod_prime_table.sv
// ----------------------------------------------------------------------------
// binomial_mod_prime_table: factorial tables modulo 1000000007
// Extends factorial / inverse-factorial tables and answers C(n,r), P(n,r).
// ----------------------------------------------------------------------------
//  channel  | signals                  | timing
//  command  | start, busy, cmd         | taken when start && !busy
//  result   | result_valid, result     | one cycle strobe, cannot stall
//
// Every multiplication goes through one bit-serial multiplier. Queries for
// combinations take 2 multiplications, for permutations 3, and an extend 1
// plus 32 squarings and 15 multiplies for the exponent p-2. An error is
// found in S_RD1 and strobed from S_DONE with no multiplication. busy is
// high while the controller is out of S_IDLE, up to and including the strobe
// cycle. After reset entry 0 reads as 1 via a flag; the stores themselves
// need no clearing pass.
// ----------------------------------------------------------------------------
module binomial_mod_prime_table
    import bmpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  bmpt_in_t  cmd,
    output logic      busy,
    output logic      result_valid,
    output bmpt_out_t result
);

    logic [VAL_W-1:0] fact_mem [TABLE_DEPTH];
    logic [VAL_W-1:0] inv_mem  [TABLE_DEPTH];

    bmpt_state_t state_reg, state_next;
    logic [IDX_W-1:0] hb_reg;
    bmpt_in_t         cmd_reg;
    logic [VAL_W-1:0] t_reg;     // running product / pow accumulator
    logic [VAL_W-1:0] f_reg;     // new factorial for extend
    logic [5:0]       bit_reg;
    logic [1:0]       st_reg;
    logic [VAL_W-1:0] val_reg;
    logic             valid_reg;

    logic [IDX_W-1:0] fa_addr, ia_addr;
    logic [VAL_W-1:0] fa_q, ia_q;
    logic             wr_en;

    logic             m_go, m_done;
    logic [VAL_W-1:0] m_a, m_b, m_p;

    bmpt_mulmod u_mul (
        .clk(clk), .rst_n(rst_n), .go(m_go), .a(m_a), .b(m_b),
        .done(m_done), .product(m_p)
    );

    logic [IDX_W-1:0] n_i, r_i, nr_i;
    assign n_i  = cmd_reg.top_index[IDX_W-1:0];
    assign r_i  = cmd_reg.choose_count[IDX_W-1:0];
    assign nr_i = n_i - r_i;

    // Entry 0 reads as 1 via an address-zero flag; write path fills the others.
    logic [VAL_W-1:0] fact_rd_reg, inv_rd_reg;
    logic fa_zero_reg, ia_zero_reg;
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fact_mem[hb_reg + 1'b1] <= f_reg;
            inv_mem[hb_reg + 1'b1]  <= t_reg;
        end
        fact_rd_reg <= fact_mem[fa_addr];
        inv_rd_reg  <= inv_mem[ia_addr];
        fa_zero_reg <= (fa_addr == '0);
        ia_zero_reg <= (ia_addr == '0);
    end
    assign fa_q = fa_zero_reg ? VAL_W'(1) : fact_rd_reg;
    assign ia_q = ia_zero_reg ? VAL_W'(1) : inv_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hb_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_next == S_DONE);
            if (wr_en)
                hb_reg <= hb_reg + 1'b1;
        end
    end

    logic ld_cmd, ld_t_fa, ld_t_m, ld_f_m, dec_bit, ld_err, ld_res, ld_bit;
    logic [1:0]       err_code;
    logic [VAL_W-1:0] res_val;

    always_comb
    begin
        state_next = state_reg;
        fa_addr = n_i;
        ia_addr = nr_i;
        m_go = 1'b0;
        m_a  = t_reg;
        m_b  = t_reg;
        wr_en = 1'b0;
        ld_cmd = 1'b0; ld_t_fa = 1'b0; ld_t_m = 1'b0; ld_f_m = 1'b0;
        dec_bit = 1'b0; ld_err = 1'b0; ld_res = 1'b0; ld_bit = 1'b0;
        err_code = ST_OK;
        res_val  = m_p;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ld_cmd = 1'b1;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                // Extend reads fact[hb]; queries read fact[n], inv[n-r].
                if (cmd_reg.operation == OP_EXTEND)
                begin
                    fa_addr = hb_reg;
                    if (hb_reg == IDX_W'(TABLE_DEPTH - 1))
                    begin
                        ld_err = 1'b1; err_code = ST_FULL; state_next = S_DONE;
                    end
                    else
                        state_next = S_RD2;
                end
                else if (cmd_reg.operation == OP_COMBINE ||
                         cmd_reg.operation == OP_PERMUTE)
                begin
                    if (cmd_reg.top_index > 12'(hb_reg))
                    begin
                        ld_err = 1'b1; err_code = ST_NOT_BUILT; state_next = S_DONE;
                    end
                    else if (cmd_reg.choose_count > cmd_reg.top_index)
                    begin
                        ld_err = 1'b1; err_code = ST_R_GT_N; state_next = S_DONE;
                    end
                    else
                        state_next = S_RD2;
                end
                else
                begin
                    ld_err = 1'b1; err_code = ST_OK; state_next = S_DONE;
                end
            end
            S_RD2:
            begin
                if (cmd_reg.operation == OP_EXTEND)
                begin
                    m_go = 1'b1;
                    m_a  = VAL_W'(hb_reg) + 1'b1;
                    m_b  = fa_q;
                    state_next = S_WAIT1;
                end
                else
                begin
                    ld_t_fa = 1'b1;   // t = n!
                    m_go = 1'b1;
                    m_a  = fa_q;
                    m_b  = ia_q;
                    ia_addr = r_i;
                    fa_addr = r_i;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                // wait for n! * inv(n-r)!; inv(r)! and r! are being read.
                ia_addr = r_i;
                fa_addr = r_i;
                if (m_done)
                begin
                    m_go = 1'b1;
                    m_a  = m_p;
                    m_b  = ia_q;
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                fa_addr = r_i;
                if (m_done)
                begin
                    if (cmd_reg.operation == OP_PERMUTE)
                    begin
                        m_go = 1'b1;
                        m_a  = m_p;
                        m_b  = fa_q;
                        state_next = S_MUL3;
                    end
                    else
                    begin
                        ld_res = 1'b1; state_next = S_DONE;
                    end
                end
            end
            S_MUL3:
            begin
                if (m_done)
                begin
                    ld_res = 1'b1; state_next = S_DONE;
                end
            end
            S_WAIT1:
            begin
                if (m_done)
                begin
                    ld_f_m = 1'b1;   // f takes the new factorial, t restarts at 1
                    ld_bit = 1'b1;
                    state_next = S_POW_SQ;
                end
            end
            S_POW_SQ:
            begin
                m_go = 1'b1;
                m_a  = t_reg;
                m_b  = t_reg;
                state_next = S_POW_SQW;
            end
            S_POW_SQW:
            begin
                if (m_done)
                begin
                    ld_t_m = 1'b1;
                    if (INV_EXPONENT[bit_reg[4:0]])
                        state_next = S_POW_ML;
                    else if (bit_reg == '0)
                        state_next = S_WRITE;
                    else
                    begin
                        dec_bit = 1'b1; state_next = S_POW_SQ;
                    end
                end
            end
            S_POW_ML:
            begin
                m_go = 1'b1;
                m_a  = t_reg;
                m_b  = f_reg;
                state_next = S_POW_MLW;
            end
            S_POW_MLW:
            begin
                if (m_done)
                begin
                    ld_t_m = 1'b1;
                    if (bit_reg == '0)
                        state_next = S_WRITE;
                    else
                    begin
                        dec_bit = 1'b1; state_next = S_POW_SQ;
                    end
                end
            end
            S_WRITE:
            begin
                wr_en = 1'b1;
                ld_res = 1'b1;
                res_val = f_reg;
                state_next = S_DONE;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld_cmd)
            cmd_reg <= cmd;
        if (ld_t_fa)
            t_reg <= fa_q;
        if (ld_f_m)
        begin
            f_reg <= m_p;
            // Square-and-multiply starts from acc = 1; leading squarings of 1 still run.
            t_reg <= VAL_W'(1);
        end
        if (ld_t_m)
            t_reg <= m_p;
        if (ld_bit)
            bit_reg <= 6'd31;
        if (dec_bit)
            bit_reg <= bit_reg - 1'b1;
        if (ld_err)
        begin
            val_reg <= '0;
            st_reg  <= err_code;
        end
        if (ld_res)
        begin
            val_reg <= res_val;
            st_reg  <= ST_OK;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = valid_reg;
    assign result.value  = val_reg;
    assign result.status = st_reg;

endmodule

// File: verif/tb_binomial_mod_prime_table.sv
// ----------------------------------------------------------------------------
// tb_binomial_mod_prime_table: self-checking bench for the factorial table
// Drives extend, combination and permutation commands in bursts. A local
// model of both stores predicts each result, and a monitor compares every
// strobed result with the oldest prediction. The run ends by filling the
// table to the top and checking the table-full response.
// ----------------------------------------------------------------------------
module tb_binomial_mod_prime_table;
    import bmpt_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [63:0] MODULUS  = 64'd1000000007;

    logic      clk;
    logic      rst_n;
    logic      start;
    bmpt_in_t  cmd;
    logic      busy;
    logic      result_valid;
    bmpt_out_t result;

    logic [VAL_W-1:0] fact_table [TABLE_DEPTH];
    logic [VAL_W-1:0] inv_fact_table [TABLE_DEPTH];
    int unsigned      built_top;
    bmpt_out_t        pending_answers [$];
    int               error_count;
    int               burst_left;

    binomial_mod_prime_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [VAL_W-1:0] mulmod(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        logic [63:0] prod;
        prod = {34'd0, a} * {34'd0, b};
        return VAL_W'(prod % MODULUS);
    endfunction

    // Square-and-multiply over all 32 exponent bits, most significant first.
    function automatic logic [VAL_W-1:0] powmod(logic [VAL_W-1:0] base, logic [31:0] ex);
        logic [VAL_W-1:0] acc;
        acc = 1;
        for (int k = 31; k >= 0; k--)
        begin
            acc = mulmod(acc, acc);
            if (ex[k])
                acc = mulmod(acc, base);
        end
        return acc;
    endfunction

    function automatic bmpt_out_t predict_beat(bmpt_in_t c);
        bmpt_out_t   ans;
        int unsigned n;
        int unsigned r;
        ans = '0;
        n = c.top_index;
        r = c.choose_count;
        case (c.operation)
            OP_EXTEND:
            begin
                if (built_top + 1 >= TABLE_DEPTH)
                    ans.status = ST_FULL;
                else
                begin
                    built_top++;
                    fact_table[built_top] = mulmod(VAL_W'(built_top),
                                                   fact_table[built_top - 1]);
                    inv_fact_table[built_top] = powmod(fact_table[built_top], INV_EXPONENT);
                    ans.value = fact_table[built_top];
                end
            end
            OP_COMBINE, OP_PERMUTE:
            begin
                // The not-built check takes priority over the r check.
                if (n > built_top)
                    ans.status = ST_NOT_BUILT;
                else if (r > n)
                    ans.status = ST_R_GT_N;
                else
                begin
                    ans.value = mulmod(fact_table[n],
                                       mulmod(inv_fact_table[n - r], inv_fact_table[r]));
                    if (c.operation == OP_PERMUTE)
                        ans.value = mulmod(ans.value, fact_table[r]);
                end
            end
            default: ans = '0;
        endcase
        return ans;
    endfunction

    // Sends one beat. With gap zero start stays high so the next call can
    // follow back to back; a later drain or gap lowers it.
    task automatic send_beat(logic [1:0] op, logic [11:0] n, logic [11:0] r, int gap);
        bmpt_in_t c;
        c.operation    = op;
        c.top_index    = n;
        c.choose_count = r;
        cmd   <= c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_answers = {pending_answers, predict_beat(c)};
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_bursty(logic [1:0] op, logic [11:0] n, logic [11:0] r);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 25);
        end
        burst_left--;
        send_beat(op, n, r, gap);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        bmpt_out_t want;
        if (rst_n && result_valid)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result beat: value %0d status %0d",
                       result.value, result.status);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (result.value !== want.value)
                begin
                    $error("value: expected %0d, actual %0d", want.value, result.value);
                    error_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, result.status);
                    error_count++;
                end
            end
        end
    end

    task automatic test_empty_table;
        send_beat(OP_COMBINE, 12'd0, 12'd0, 0);
        send_beat(OP_PERMUTE, 12'd0, 12'd0, 1);
        send_beat(OP_COMBINE, 12'd1, 12'd0, 0);
        send_beat(OP_PERMUTE, 12'd4095, 12'd4095, 0);
        send_beat(OP_COMBINE, 12'd0, 12'd4095, 2);
        send_beat(OP_UNUSED, 12'd4095, 12'd4095, 0);
        drain();
    endtask

    task automatic test_small_table;
        for (int k = 0; k < 8; k++)
            send_beat(OP_EXTEND, 12'($urandom), 12'($urandom), k % 3);
        send_beat(OP_COMBINE, 12'd8, 12'd3, 0);
        send_beat(OP_PERMUTE, 12'd8, 12'd8, 0);
        send_beat(OP_COMBINE, 12'd8, 12'd8, 1);
        send_beat(OP_PERMUTE, 12'd5, 12'd6, 0);
        send_beat(OP_COMBINE, 12'd9, 12'd0, 0);
        send_beat(OP_UNUSED, 12'd3, 12'd1, 0);
        drain();
    endtask

    task automatic test_random_mix;
        int          pick;
        logic [11:0] n;
        logic [11:0] r;
        for (int k = 0; k < 650; k++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 4) != 0)
                n = 12'($urandom_range(0, built_top));
            else
                n = 12'($urandom);
            if ($urandom_range(0, 6) != 0)
                r = 12'($urandom_range(0, n));
            else
                r = 12'($urandom);
            if (pick < 8)
                send_bursty(OP_EXTEND, 12'($urandom), 12'($urandom));
            else if (pick < 12)
                send_bursty(OP_UNUSED, n, r);
            else if (pick < 56)
                send_bursty(OP_COMBINE, n, r);
            else
                send_bursty(OP_PERMUTE, n, r);
            // Now and then hold the next command until all results are back.
            if (k % 150 == 149)
                drain();
        end
        drain();
    endtask

    task automatic test_fill_table;
        while (built_top + 1 < TABLE_DEPTH)
            send_beat(OP_EXTEND, 12'd0, 12'd0, 0);
        send_beat(OP_EXTEND, 12'hfff, 12'hfff, 0);
        send_beat(OP_COMBINE, 12'd4095, 12'd4095, 0);
        send_beat(OP_PERMUTE, 12'd4095, 12'd4095, 0);
        send_beat(OP_COMBINE, 12'd4095, 12'd2048, 0);
        send_beat(OP_PERMUTE, 12'd4095, 12'd1, 0);
        send_beat(OP_COMBINE, 12'd2730, 12'd1365, 0);
        for (int k = 0; k < 20; k++)
            send_bursty(k[0] ? OP_PERMUTE : OP_COMBINE, 12'($urandom), 12'($urandom));
        send_beat(OP_EXTEND, 12'd0, 12'd0, 1);
        drain();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        error_count = 0;
        burst_left  = 0;
        built_top   = 0;
        fact_table[0]     = 1;
        inv_fact_table[0] = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_small_table();
        test_random_mix();
        test_fill_table();
        if (error_count == 0)
            $display("tb_binomial_mod_prime_table: clean");
        else
            $display("tb_binomial_mod_prime_table: errors");
        $finish;
    end

    // Filling the table costs roughly 4100 extends.
    initial
    begin
        #400000000;
        $display("tb_binomial_mod_prime_table: errors");
        $finish;
    end

endmodule
